FILE: rtl/tksd_pkg.sv
// types and constants shared by the terminal key sequence decoder
`timescale 1ns / 1ps

package tksd_pkg;

    // one input transfer: a raw byte or a flush marker
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } key_byte_t;

    // one decoded key event
    typedef struct packed {
        logic [4:0]  key_kind;
        logic [20:0] code_point;
        logic [31:0] utf8_bytes;
        logic [2:0]  utf8_length;
        logic        mod_shift;
        logic        mod_alt;
        logic        mod_ctrl;
        logic [2:0]  mouse_button;
        logic [1:0]  mouse_action;
        logic [15:0] mouse_column;
        logic [15:0] mouse_row;
        logic        last_of_run;
    } key_event_t;

    // input actions
    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // key kinds
    localparam logic [4:0] KIND_CHAR      = 5'd0;
    localparam logic [4:0] KIND_CTRL      = 5'd1;
    localparam logic [4:0] KIND_ENTER     = 5'd2;
    localparam logic [4:0] KIND_TAB       = 5'd3;
    localparam logic [4:0] KIND_BACKSPACE = 5'd4;
    localparam logic [4:0] KIND_ESC       = 5'd5;
    localparam logic [4:0] KIND_UP        = 5'd6;
    localparam logic [4:0] KIND_DOWN      = 5'd7;
    localparam logic [4:0] KIND_RIGHT     = 5'd8;
    localparam logic [4:0] KIND_LEFT      = 5'd9;
    localparam logic [4:0] KIND_HOME      = 5'd10;
    localparam logic [4:0] KIND_END       = 5'd11;
    localparam logic [4:0] KIND_INSERT    = 5'd12;
    localparam logic [4:0] KIND_DELETE    = 5'd13;
    localparam logic [4:0] KIND_PGUP      = 5'd14;
    localparam logic [4:0] KIND_PGDN      = 5'd15;
    localparam logic [4:0] KIND_MOUSE     = 5'd16;

    // mouse buttons
    localparam logic [2:0] BTN_NONE       = 3'd0;
    localparam logic [2:0] BTN_LEFT       = 3'd1;
    localparam logic [2:0] BTN_MIDDLE     = 3'd2;
    localparam logic [2:0] BTN_RIGHT      = 3'd3;
    localparam logic [2:0] BTN_WHEEL_UP   = 3'd4;
    localparam logic [2:0] BTN_WHEEL_DOWN = 3'd5;

    // mouse actions
    localparam logic [1:0] MACT_PRESS   = 2'd0;
    localparam logic [1:0] MACT_RELEASE = 2'd1;
    localparam logic [1:0] MACT_DRAG    = 2'd2;

    // control and sequence bytes
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] BYTE_LF       = 8'h0A;
    localparam logic [7:0] BYTE_TAB      = 8'h09;
    localparam logic [7:0] BYTE_DEL      = 8'h7F;
    localparam logic [7:0] BYTE_BS       = 8'h08;
    localparam logic [7:0] BYTE_SPACE    = 8'h20;
    localparam logic [7:0] BYTE_ZERO     = 8'h30;
    localparam logic [7:0] BYTE_NINE     = 8'h39;
    localparam logic [7:0] BYTE_SEMI     = 8'h3B;
    localparam logic [7:0] BYTE_LESS     = 8'h3C;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_SS3      = 8'h4F;
    localparam logic [7:0] BYTE_FINAL_LO = 8'h40;
    localparam logic [7:0] BYTE_FINAL_HI = 8'h7E;
    localparam logic [7:0] BYTE_TILDE    = 8'h7E;
    localparam logic [7:0] BYTE_KEY_A    = 8'h41;
    localparam logic [7:0] BYTE_KEY_B    = 8'h42;
    localparam logic [7:0] BYTE_KEY_C    = 8'h43;
    localparam logic [7:0] BYTE_KEY_D    = 8'h44;
    localparam logic [7:0] BYTE_KEY_F    = 8'h46;
    localparam logic [7:0] BYTE_KEY_H    = 8'h48;
    localparam logic [7:0] BYTE_KEY_Z    = 8'h5A;
    localparam logic [7:0] BYTE_MOUSE_DN = 8'h4D;
    localparam logic [7:0] BYTE_MOUSE_UP = 8'h6D;
    localparam logic [7:0] CTRL_OFFSET   = 8'h60;

    // replacement character
    localparam logic [20:0] REPL_CP    = 21'h00FFFD;
    localparam logic [31:0] REPL_BYTES = 32'h00BDBFEF;
    localparam logic [2:0]  REPL_LEN   = 3'd3;

    // most results one input transfer may cause
    localparam int MAX_RESULTS = 4;

endpackage

FILE: rtl/terminal_key_sequence_decoder_core.sv
// terminal key sequence decoder: bytes in, key and mouse events out
`timescale 1ns / 1ps

// Takes one terminal byte (or a flush marker) per transfer and produces decoded key events:
// control keys, CSI/SS3 cursor and tilde keys with modifiers, SGR mouse reports and strict
// UTF-8 characters. A byte is normally taken every cycle while the event queue has room. When
// an escape is followed by a byte that does not open a sequence, or a UTF-8 sequence turns out
// malformed, the bytes concerned are decoded again from a three-byte replay buffer, one byte
// per cycle while the queue has room, and the input is stalled until the replay is done (a
// replayed byte may itself start a malformed sequence or an escape that sends later bytes round
// again). Events leave one per cycle, unless the receiver stalls, through a four-entry queue
// behind a one-event hold register that marks the last event of each transfer. A byte causes
// at most four events.
module terminal_key_sequence_decoder_core
    import tksd_pkg::*;
#(
    parameter int PARAM_WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  key_byte_t  byte_item,
    output logic       event_valid,
    input  logic       event_stall,
    output key_event_t event_item
);

    localparam int EVQ_DEPTH = 4;
    localparam int PTR_W     = $clog2(EVQ_DEPTH);
    localparam int CNT_W     = $clog2(EVQ_DEPTH + 1);
    localparam int RUN_W     = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] MODE_GROUND = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_OPEN   = 3'd2;
    localparam logic [2:0] MODE_CSI    = 3'd3;
    localparam logic [2:0] MODE_MOUSE  = 3'd4;
    localparam logic [2:0] MODE_UTF8   = 3'd5;

    // parser state
    logic [2:0]             mode_reg, mode_next;
    logic [PARAM_WIDTH-1:0] first_reg, first_next;
    logic [PARAM_WIDTH-1:0] second_reg, second_next;
    logic                   seen_reg, seen_next;
    logic                   insec_reg, insec_next;
    logic [PARAM_WIDTH-1:0] mf_reg [3];
    logic [PARAM_WIDTH-1:0] mf_next [3];
    logic [1:0]             midx_reg, midx_next;
    logic [23:0]            pend_reg, pend_next;
    logic [1:0]             ucnt_reg, ucnt_next;
    logic [2:0]             uneed_reg, uneed_next;

    // replay buffer, front entry first
    logic [7:0]             replay_reg [3];
    logic [7:0]             replay_next [3];
    logic [1:0]             rcount_reg, rcount_next;
    logic [RUN_W-1:0]       run_reg, run_next;

    // hold register and event queue
    key_event_t             hold_reg, hold_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic                   hold_final_reg, hold_final_next;
    key_event_t             fifo_reg [EVQ_DEPTH];
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    // step control
    logic                   fifo_room;
    logic                   accept;
    logic                   replay_go;
    logic                   step;
    logic                   cur_flush;
    logic [7:0]             b;
    logic                   is_digit;
    logic [7:0]             rest [3];
    logic [1:0]             rest_cnt;

    // step results
    key_event_t             res;
    logic                   res_valid;
    logic [7:0]             ins [3];
    logic [1:0]             ins_cnt;
    logic                   end_run;
    logic [RUN_W-1:0]       run_base;
    logic                   keep;
    logic                   wr_en;
    logic                   rd_en;
    key_event_t             wr_data;

    // csi decode
    logic [PARAM_WIDTH-1:0] csi_first, csi_second;
    logic                   csi_seen, csi_insec, csi_final;
    key_event_t             csi_ev;
    logic [PARAM_WIDTH-1:0] mod_m;

    // mouse decode
    key_event_t             mouse_ev;
    logic [PARAM_WIDTH-1:0] mcol_w, mrow_w;

    // utf-8 decode
    logic [7:0]             bs0, bs1, bs2, bs3;
    logic                   cont_ok, utf_ok;
    logic [20:0]            utf_cp;

    // decimal accumulate, saturating at the accumulator width
    function automatic logic [PARAM_WIDTH-1:0] acc_digit(
        input logic [PARAM_WIDTH-1:0] v,
        input logic [7:0]             d
    );
        logic [PARAM_WIDTH+3:0] s;
        s = ({4'd0, v} << 3) + ({4'd0, v} << 1) + (PARAM_WIDTH+4)'(d - BYTE_ZERO);
        return (s[PARAM_WIDTH+3:PARAM_WIDTH] != 4'd0) ? '1 : s[PARAM_WIDTH-1:0];
    endfunction

    // source of the byte worked on this cycle
    assign fifo_room  = (count_reg != CNT_W'(EVQ_DEPTH));
    assign byte_stall = (rcount_reg != 2'd0) || !fifo_room;
    assign accept     = byte_valid && !byte_stall;
    assign replay_go  = (rcount_reg != 2'd0) && fifo_room;
    assign step       = accept || replay_go;
    assign cur_flush  = !replay_go && (byte_item.action == ACT_FLUSH);
    assign b          = replay_go ? replay_reg[0] : byte_item.data_byte;
    assign is_digit   = (b >= BYTE_ZERO) && (b <= BYTE_NINE);

    // replay entries left after taking the front one
    assign rest[0]  = replay_reg[1];
    assign rest[1]  = replay_reg[2];
    assign rest[2]  = 8'd0;
    assign rest_cnt = replay_go ? (rcount_reg - 2'd1) : 2'd0;

    // csi body and final byte
    assign mod_m = second_reg - PARAM_WIDTH'(1);
    always_comb
    begin
        csi_first  = first_reg;
        csi_second = second_reg;
        csi_seen   = seen_reg;
        csi_insec  = insec_reg;
        csi_final  = 1'b0;
        csi_ev     = '0;
        if ((b < BYTE_FINAL_LO) || (b > BYTE_FINAL_HI))
        begin
            if (is_digit)
            begin
                if (!insec_reg)
                begin
                    csi_first = acc_digit(first_reg, b);
                end
                else
                begin
                    csi_second = acc_digit(second_reg, b);
                    csi_seen   = 1'b1;
                end
            end
            else if (b == BYTE_SEMI)
            begin
                csi_insec = 1'b1;
            end
        end
        else
        begin
            csi_final = 1'b1;
            if (seen_reg && (second_reg >= PARAM_WIDTH'(2)))
            begin
                csi_ev.mod_shift = mod_m[0];
                csi_ev.mod_alt   = mod_m[1];
                csi_ev.mod_ctrl  = mod_m[2];
            end
            unique case (b)
                BYTE_KEY_A: csi_ev.key_kind = KIND_UP;
                BYTE_KEY_B: csi_ev.key_kind = KIND_DOWN;
                BYTE_KEY_C: csi_ev.key_kind = KIND_RIGHT;
                BYTE_KEY_D: csi_ev.key_kind = KIND_LEFT;
                BYTE_KEY_H: csi_ev.key_kind = KIND_HOME;
                BYTE_KEY_F: csi_ev.key_kind = KIND_END;
                BYTE_KEY_Z:
                begin
                    csi_ev.key_kind  = KIND_TAB;
                    csi_ev.mod_shift = 1'b1;
                end
                BYTE_TILDE:
                begin
                    priority if (first_reg == PARAM_WIDTH'(1) || first_reg == PARAM_WIDTH'(7))
                        csi_ev.key_kind = KIND_HOME;
                    else if (first_reg == PARAM_WIDTH'(2))
                        csi_ev.key_kind = KIND_INSERT;
                    else if (first_reg == PARAM_WIDTH'(4) || first_reg == PARAM_WIDTH'(8))
                        csi_ev.key_kind = KIND_END;
                    else if (first_reg == PARAM_WIDTH'(3))
                        csi_ev.key_kind = KIND_DELETE;
                    else if (first_reg == PARAM_WIDTH'(5))
                        csi_ev.key_kind = KIND_PGUP;
                    else if (first_reg == PARAM_WIDTH'(6))
                        csi_ev.key_kind = KIND_PGDN;
                    else
                        csi_ev.key_kind = KIND_ESC;
                end
                default: csi_ev.key_kind = KIND_ESC;
            endcase
        end
    end

    // sgr mouse report from the collected fields
    assign mcol_w = (mf_reg[1] != '0) ? (mf_reg[1] - PARAM_WIDTH'(1)) : '0;
    assign mrow_w = (mf_reg[2] != '0) ? (mf_reg[2] - PARAM_WIDTH'(1)) : '0;
    always_comb
    begin
        mouse_ev              = '0;
        mouse_ev.key_kind     = KIND_MOUSE;
        mouse_ev.mod_shift    = mf_reg[0][2];
        mouse_ev.mod_alt      = mf_reg[0][3];
        mouse_ev.mod_ctrl     = mf_reg[0][4];
        mouse_ev.mouse_column = 16'(mcol_w);
        mouse_ev.mouse_row    = 16'(mrow_w);
        if (mf_reg[0][6])
        begin
            mouse_ev.mouse_button = mf_reg[0][0] ? BTN_WHEEL_DOWN : BTN_WHEEL_UP;
            mouse_ev.mouse_action = MACT_PRESS;
        end
        else
        begin
            unique case (mf_reg[0][1:0])
                2'd0:    mouse_ev.mouse_button = BTN_LEFT;
                2'd1:    mouse_ev.mouse_button = BTN_MIDDLE;
                2'd2:    mouse_ev.mouse_button = BTN_RIGHT;
                default: mouse_ev.mouse_button = BTN_NONE;
            endcase
            if (b == BYTE_MOUSE_UP)
                mouse_ev.mouse_action = MACT_RELEASE;
            else if (mf_reg[0][5])
                mouse_ev.mouse_action = MACT_DRAG;
            else
                mouse_ev.mouse_action = MACT_PRESS;
        end
    end

    // utf-8 sequence check once the lead's length is held
    assign bs0 = pend_reg[7:0];
    assign bs1 = (ucnt_reg >= 2'd2) ? pend_reg[15:8] : b;
    assign bs2 = (ucnt_reg == 2'd3) ? pend_reg[23:16] : ((ucnt_reg == 2'd2) ? b : 8'd0);
    assign bs3 = (ucnt_reg == 2'd3) ? b : 8'd0;
    assign cont_ok = (bs1[7:6] == 2'b10)
                   && ((ucnt_reg < 2'd2) || (bs2[7:6] == 2'b10))
                   && ((ucnt_reg < 2'd3) || (bs3[7:6] == 2'b10));
    always_comb
    begin
        unique case (ucnt_reg)
            2'd1:
            begin
                utf_ok = cont_ok && (bs0 >= 8'hC2);
                utf_cp = {10'd0, bs0[4:0], bs1[5:0]};
            end
            2'd2:
            begin
                utf_ok = cont_ok && !((bs0 == 8'hE0) && (bs1 < 8'hA0))
                                 && !((bs0 == 8'hED) && (bs1 > 8'h9F));
                utf_cp = {5'd0, bs0[3:0], bs1[5:0], bs2[5:0]};
            end
            default:
            begin
                utf_ok = cont_ok && (bs0 <= 8'hF4)
                                 && !((bs0 == 8'hF0) && (bs1 < 8'h90))
                                 && !((bs0 == 8'hF4) && (bs1 > 8'h8F));
                utf_cp = {bs0[2:0], bs1[5:0], bs2[5:0], bs3[5:0]};
            end
        endcase
    end

    // one decode step on the current byte
    always_comb
    begin
        logic do_csi;
        do_csi      = 1'b0;
        mode_next   = mode_reg;
        first_next  = first_reg;
        second_next = second_reg;
        seen_next   = seen_reg;
        insec_next  = insec_reg;
        mf_next[0]  = mf_reg[0];
        mf_next[1]  = mf_reg[1];
        mf_next[2]  = mf_reg[2];
        midx_next   = midx_reg;
        pend_next   = pend_reg;
        ucnt_next   = ucnt_reg;
        uneed_next  = uneed_reg;
        res         = '0;
        res_valid   = 1'b0;
        ins[0]      = 8'd0;
        ins[1]      = 8'd0;
        ins[2]      = 8'd0;
        ins_cnt     = 2'd0;
        if (cur_flush)
        begin
            if (mode_reg == MODE_ESC)
            begin
                res.key_kind = KIND_ESC;
                res_valid    = 1'b1;
                mode_next    = MODE_GROUND;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    first_next  = '0;
                    second_next = '0;
                    seen_next   = 1'b0;
                    insec_next  = 1'b0;
                    if (b == BYTE_LBRACKET)
                    begin
                        mode_next = MODE_OPEN;
                    end
                    else if (b == BYTE_SS3)
                    begin
                        mode_next = MODE_CSI;
                    end
                    else
                    begin
                        // lone escape, byte decoded again from ground
                        res.key_kind = KIND_ESC;
                        res_valid    = 1'b1;
                        mode_next    = MODE_GROUND;
                        ins[0]       = b;
                        ins_cnt      = 2'd1;
                    end
                end
                MODE_OPEN:
                begin
                    if (b == BYTE_LESS)
                    begin
                        mode_next  = MODE_MOUSE;
                        mf_next[0] = '0;
                        mf_next[1] = '0;
                        mf_next[2] = '0;
                        midx_next  = 2'd0;
                    end
                    else
                    begin
                        mode_next = MODE_CSI;
                        do_csi    = 1'b1;
                    end
                end
                MODE_CSI:
                begin
                    do_csi = 1'b1;
                end
                MODE_MOUSE:
                begin
                    if (is_digit)
                    begin
                        unique case (midx_reg)
                            2'd0:    mf_next[0] = acc_digit(mf_reg[0], b);
                            2'd1:    mf_next[1] = acc_digit(mf_reg[1], b);
                            2'd2:    mf_next[2] = acc_digit(mf_reg[2], b);
                            default: mf_next[0] = mf_reg[0];
                        endcase
                    end
                    else if (b == BYTE_SEMI)
                    begin
                        if (midx_reg != 2'd3)
                            midx_next = midx_reg + 2'd1;
                    end
                    else if ((b == BYTE_MOUSE_DN) || (b == BYTE_MOUSE_UP))
                    begin
                        res       = mouse_ev;
                        res_valid = 1'b1;
                        mode_next = MODE_GROUND;
                    end
                end
                MODE_UTF8:
                begin
                    if ((({1'b0, ucnt_reg} + 3'd1) < uneed_reg) && (ucnt_reg != 2'd3))
                    begin
                        unique case (ucnt_reg)
                            2'd1:    pend_next[15:8]  = b;
                            2'd2:    pend_next[23:16] = b;
                            default: pend_next[7:0]   = pend_reg[7:0] | b;
                        endcase
                        ucnt_next = ucnt_reg + 2'd1;
                    end
                    else
                    begin
                        mode_next  = MODE_GROUND;
                        ucnt_next  = 2'd0;
                        uneed_next = 3'd0;
                        res_valid  = 1'b1;
                        if ((ucnt_reg != 2'd0) && utf_ok)
                        begin
                            res.code_point  = utf_cp;
                            res.utf8_bytes  = {bs3, bs2, bs1, bs0};
                            res.utf8_length = {1'b0, ucnt_reg} + 3'd1;
                        end
                        else
                        begin
                            // replacement, bytes after the lead decoded again
                            res.code_point  = REPL_CP;
                            res.utf8_bytes  = REPL_BYTES;
                            res.utf8_length = REPL_LEN;
                            ins[0]          = bs1;
                            ins[1]          = bs2;
                            ins[2]          = bs3;
                            ins_cnt         = ucnt_reg;
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_GROUND;
                    priority if (b == BYTE_ESC)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else if ((b == BYTE_CR) || (b == BYTE_LF))
                    begin
                        res.key_kind = KIND_ENTER;
                        res_valid    = 1'b1;
                    end
                    else if (b == BYTE_TAB)
                    begin
                        res.key_kind = KIND_TAB;
                        res_valid    = 1'b1;
                    end
                    else if ((b == BYTE_DEL) || (b == BYTE_BS))
                    begin
                        res.key_kind = KIND_BACKSPACE;
                        res_valid    = 1'b1;
                    end
                    else if (b < BYTE_SPACE)
                    begin
                        res.key_kind   = KIND_CTRL;
                        res.code_point = {13'd0, b + CTRL_OFFSET};
                        res_valid      = 1'b1;
                    end
                    else if (b < 8'h80)
                    begin
                        res.code_point  = {13'd0, b};
                        res.utf8_bytes  = {24'd0, b};
                        res.utf8_length = 3'd1;
                        res_valid       = 1'b1;
                    end
                    else if (((b & 8'hE0) == 8'hC0) || ((b & 8'hF0) == 8'hE0)
                             || ((b & 8'hF8) == 8'hF0))
                    begin
                        // lead byte, start collecting
                        pend_next = {16'd0, b};
                        ucnt_next = 2'd1;
                        mode_next = MODE_UTF8;
                        if ((b & 8'hE0) == 8'hC0)
                            uneed_next = 3'd2;
                        else if ((b & 8'hF0) == 8'hE0)
                            uneed_next = 3'd3;
                        else
                            uneed_next = 3'd4;
                    end
                    else
                    begin
                        // stray continuation or invalid lead
                        res.code_point  = REPL_CP;
                        res.utf8_bytes  = REPL_BYTES;
                        res.utf8_length = REPL_LEN;
                        res_valid       = 1'b1;
                    end
                end
            endcase
            if (do_csi)
            begin
                first_next  = csi_first;
                second_next = csi_second;
                seen_next   = csi_seen;
                insec_next  = csi_insec;
                if (csi_final)
                begin
                    res       = csi_ev;
                    res_valid = 1'b1;
                    mode_next = MODE_GROUND;
                end
            end
        end
    end

    // replay buffer update: re-read bytes go ahead of the remaining ones
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (j < int'(ins_cnt))
                replay_next[j] = ins[j];
            else
                replay_next[j] = rest[2'(j - int'(ins_cnt))];
        end
        rcount_next = ins_cnt + rest_cnt;
    end

    assign end_run  = (rcount_next == 2'd0);
    assign run_base = replay_go ? run_reg : '0;
    assign keep     = res_valid && (run_base < RUN_W'(MAX_RESULTS));
    assign run_next = run_base + RUN_W'(keep);

    // hold register: the latest event waits until its run is known to end
    assign wr_en = fifo_room && hold_valid_reg && (hold_final_reg || (step && keep));
    always_comb
    begin
        wr_data             = hold_reg;
        wr_data.last_of_run = hold_final_reg;
        hold_next           = hold_reg;
        hold_valid_next     = hold_valid_reg;
        hold_final_next     = hold_final_reg;
        if (step && keep)
        begin
            hold_next       = res;
            hold_valid_next = 1'b1;
            hold_final_next = end_run;
        end
        else if (wr_en)
        begin
            hold_valid_next = 1'b0;
            hold_final_next = 1'b0;
        end
        else if (step && end_run && hold_valid_reg)
        begin
            hold_final_next = 1'b1;
        end
    end

    // event queue
    assign event_valid = (count_reg != '0);
    assign event_item  = fifo_reg[head_reg];
    assign rd_en       = event_valid && !event_stall;
    assign head_next   = rd_en ? (head_reg + PTR_W'(1)) : head_reg;
    assign tail_next   = wr_en ? (tail_reg + PTR_W'(1)) : tail_reg;
    assign count_next  = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);

    // control and parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_GROUND;
            first_reg      <= '0;
            second_reg     <= '0;
            seen_reg       <= 1'b0;
            insec_reg      <= 1'b0;
            mf_reg[0]      <= '0;
            mf_reg[1]      <= '0;
            mf_reg[2]      <= '0;
            midx_reg       <= 2'd0;
            ucnt_reg       <= 2'd0;
            uneed_reg      <= 3'd0;
            rcount_reg     <= 2'd0;
            run_reg        <= '0;
            hold_valid_reg <= 1'b0;
            hold_final_reg <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (step)
            begin
                mode_reg   <= mode_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                seen_reg   <= seen_next;
                insec_reg  <= insec_next;
                mf_reg[0]  <= mf_next[0];
                mf_reg[1]  <= mf_next[1];
                mf_reg[2]  <= mf_next[2];
                midx_reg   <= midx_next;
                ucnt_reg   <= ucnt_next;
                uneed_reg  <= uneed_next;
                rcount_reg <= rcount_next;
                run_reg    <= run_next;
            end
            hold_valid_reg <= hold_valid_next;
            hold_final_reg <= hold_final_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pend_reg      <= pend_next;
            replay_reg[0] <= replay_next[0];
            replay_reg[1] <= replay_next[1];
            replay_reg[2] <= replay_next[2];
        end
        hold_reg <= hold_next;
        if (wr_en)
            fifo_reg[tail_reg] <= wr_data;
    end

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(EVQ_DEPTH))
        else $error("event queue overfilled");

    // a final mark only on a held event
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_final_reg |-> hold_valid_reg)
        else $error("final mark without held event");

    // collecting utf-8 keeps count below the lead's length
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_UTF8) |->
            ((ucnt_reg != 2'd0) && ({1'b0, ucnt_reg} < uneed_reg) && (uneed_reg <= 3'd4)))
        else $error("utf-8 collection count out of range");

    // held utf-8 bytes and replay bytes fit the three-byte window
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_UTF8) |-> (({1'b0, rcount_reg} + {1'b0, ucnt_reg}) <= 3'd3))
        else $error("replay and held bytes exceed window");

endmodule

FILE: tb/sv/testbench.sv
// testbench for the terminal key sequence decoder core
`timescale 1ns / 1ps

module testbench;
    import tksd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 455;

    // parser states of the predictor
    localparam logic [2:0] ST_GROUND = 3'd0;
    localparam logic [2:0] ST_ESC    = 3'd1;
    localparam logic [2:0] ST_OPEN   = 3'd2;
    localparam logic [2:0] ST_CSI    = 3'd3;
    localparam logic [2:0] ST_MOUSE  = 3'd4;
    localparam logic [2:0] ST_UTF8   = 3'd5;

    typedef struct {
        key_byte_t  item;
        int         gap;
        bit         drain;
        bit         hold;
        bit         fixed;
        key_event_t fixed_event;
    } plan_entry_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid;
    logic       byte_stall;
    key_byte_t  byte_item;
    logic       event_valid;
    logic       event_stall;
    key_event_t event_item;

    plan_entry_t byte_plan[$];
    plan_entry_t offered;
    key_event_t  awaited_events[$];
    key_event_t  step_events[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_gap = 0;
    int          rx_gap = 0;
    int          hold_left = 0;
    logic        hold_start;
    logic        hold_on = 1'b0;

    // predictor state
    logic [2:0]  mode = ST_GROUND;
    logic [15:0] param_a = '0, param_b = '0;
    logic        param_b_seen = 1'b0, in_param_b = 1'b0;
    logic [15:0] mouse_acc [3] = '{default: '0};
    logic [1:0]  mouse_idx = '0;
    logic [23:0] held_utf8 = '0;
    logic [2:0]  utf8_have = '0, utf8_goal = '0;

    terminal_key_sequence_decoder_core dut (
        .clk(clk), .rst_n(rst_n),
        .byte_valid(byte_valid), .byte_stall(byte_stall), .byte_item(byte_item),
        .event_valid(event_valid), .event_stall(event_stall), .event_item(event_item)
    );

    always #6 clk = ~clk;

    function automatic key_event_t make_event(logic [4:0] kind, logic [20:0] cp,
                                              logic [31:0] enc, logic [2:0] len);
        key_event_t ev;
        ev = '0;
        ev.key_kind = kind;
        ev.code_point = cp;
        ev.utf8_bytes = enc;
        ev.utf8_length = len;
        return ev;
    endfunction

    function automatic void add_event(key_event_t ev);
        if (step_events.size() < MAX_RESULTS)
            step_events.push_back(ev);
    endfunction

    // decimal accumulate, saturating at 16 bits
    function automatic logic [15:0] sat_acc(logic [15:0] v, logic [7:0] b);
        int unsigned t;
        t = v * 10 + (b - BYTE_ZERO);
        return (t > 65535) ? 16'hFFFF : t[15:0];
    endfunction

    function automatic void csi_step(logic [7:0] b);
        key_event_t ev;
        logic [15:0] m;
        if (b < BYTE_FINAL_LO || b > BYTE_FINAL_HI) begin
            if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
                if (!in_param_b) param_a = sat_acc(param_a, b);
                else
                begin
                    param_b = sat_acc(param_b, b);
                    param_b_seen = 1'b1;
                end
            end
            else if (b == BYTE_SEMI)
                in_param_b = 1'b1;
            return;
        end
        ev = '0;
        if (param_b_seen && param_b >= 2) begin
            m = param_b - 16'd1;
            ev.mod_shift = m[0];
            ev.mod_alt = m[1];
            ev.mod_ctrl = m[2];
        end
        case (b)
            BYTE_KEY_A: ev.key_kind = KIND_UP;
            BYTE_KEY_B: ev.key_kind = KIND_DOWN;
            BYTE_KEY_C: ev.key_kind = KIND_RIGHT;
            BYTE_KEY_D: ev.key_kind = KIND_LEFT;
            BYTE_KEY_H: ev.key_kind = KIND_HOME;
            BYTE_KEY_F: ev.key_kind = KIND_END;
            BYTE_KEY_Z:
            begin
                ev.key_kind = KIND_TAB;
                ev.mod_shift = 1'b1;
            end
            BYTE_TILDE:
                case (param_a)
                    1, 7: ev.key_kind = KIND_HOME;
                    2: ev.key_kind = KIND_INSERT;
                    4, 8: ev.key_kind = KIND_END;
                    3: ev.key_kind = KIND_DELETE;
                    5: ev.key_kind = KIND_PGUP;
                    6: ev.key_kind = KIND_PGDN;
                    default: ev.key_kind = KIND_ESC;
                endcase
            default: ev.key_kind = KIND_ESC;
        endcase
        add_event(ev);
        mode = ST_GROUND;
    endfunction

    function automatic void mouse_step(logic [7:0] b);
        key_event_t ev;
        logic [15:0] cb;
        if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
            if (mouse_idx < 3) mouse_acc[mouse_idx] = sat_acc(mouse_acc[mouse_idx], b);
            return;
        end
        if (b == BYTE_SEMI) begin
            if (mouse_idx < 3) mouse_idx++;
            return;
        end
        if (b != BYTE_MOUSE_DN && b != BYTE_MOUSE_UP) return;
        cb = mouse_acc[0];
        ev = '0;
        ev.key_kind = KIND_MOUSE;
        ev.mod_shift = cb[2];
        ev.mod_alt = cb[3];
        ev.mod_ctrl = cb[4];
        if (cb[6]) begin
            ev.mouse_button = cb[0] ? BTN_WHEEL_DOWN : BTN_WHEEL_UP;
            ev.mouse_action = MACT_PRESS;
        end
        else
        begin
            ev.mouse_button = (cb[1:0] == 2'd3) ? BTN_NONE : {1'b0, cb[1:0]} + 3'd1;
            ev.mouse_action = (b == BYTE_MOUSE_UP) ? MACT_RELEASE :
                              (cb[5] ? MACT_DRAG : MACT_PRESS);
        end
        ev.mouse_column = (mouse_acc[1] > 0) ? mouse_acc[1] - 16'd1 : 16'd0;
        ev.mouse_row = (mouse_acc[2] > 0) ? mouse_acc[2] - 16'd1 : 16'd0;
        add_event(ev);
        mode = ST_GROUND;
    endfunction

    // strict utf-8 check of a complete group, returning the code point
    function automatic bit utf8_good(logic [7:0] bs [4], int len, output logic [20:0] cp);
        cp = '0;
        for (int i = 1; i < len; i++)
            if (bs[i][7:6] != 2'b10) return 1'b0;
        if (len == 2) begin
            if (bs[0] < 8'hC2) return 1'b0;
            cp = {10'b0, bs[0][4:0], bs[1][5:0]};
        end
        else if (len == 3) begin
            if (bs[0] == 8'hE0 && bs[1] < 8'hA0) return 1'b0;
            if (bs[0] == 8'hED && bs[1] > 8'h9F) return 1'b0;
            cp = {5'b0, bs[0][3:0], bs[1][5:0], bs[2][5:0]};
        end
        else
        begin
            if (bs[0] > 8'hF4) return 1'b0;
            if (bs[0] == 8'hF0 && bs[1] < 8'h90) return 1'b0;
            if (bs[0] == 8'hF4 && bs[1] > 8'h8F) return 1'b0;
            cp = {bs[0][2:0], bs[1][5:0], bs[2][5:0], bs[3][5:0]};
        end
        return 1'b1;
    endfunction

    // works out the events that one transfer causes, updating the parser state
    function automatic void decode_transfer(key_byte_t it);
        logic [7:0]  replay[$];
        logic [7:0]  b;
        logic [7:0]  bs [4];
        logic [20:0] cp;
        logic [31:0] enc;
        int          total;
        step_events.delete();
        if (it.action == ACT_FLUSH) begin
            if (mode == ST_ESC) begin
                add_event(make_event(KIND_ESC, '0, '0, '0));
                mode = ST_GROUND;
            end
        end
        else
        begin
            replay.push_back(it.data_byte);
            while (replay.size() > 0) begin
                b = replay.pop_back();
                case (mode)
                    ST_ESC:
                    begin
                        param_a = '0;
                        param_b = '0;
                        param_b_seen = 1'b0;
                        in_param_b = 1'b0;
                        if (b == BYTE_LBRACKET) mode = ST_OPEN;
                        else if (b == BYTE_SS3) mode = ST_CSI;
                        else
                        begin
                            add_event(make_event(KIND_ESC, '0, '0, '0));
                            mode = ST_GROUND;
                            if (replay.size() < 8) replay.push_back(b);
                        end
                    end
                    ST_OPEN:
                        if (b == BYTE_LESS) begin
                            mode = ST_MOUSE;
                            mouse_acc = '{default: '0};
                            mouse_idx = '0;
                        end
                        else
                        begin
                            mode = ST_CSI;
                            csi_step(b);
                        end
                    ST_CSI: csi_step(b);
                    ST_MOUSE: mouse_step(b);
                    ST_UTF8:
                        if (utf8_have + 1 < utf8_goal && utf8_have < 3) begin
                            held_utf8 = held_utf8 | (24'(b) << (8 * utf8_have));
                            utf8_have++;
                        end
                        else
                        begin
                            total = utf8_have + 1;
                            bs = '{default: '0};
                            for (int i = 0; i < utf8_have && i < 3; i++)
                                bs[i] = held_utf8[8*i +: 8];
                            bs[total - 1] = b;
                            mode = ST_GROUND;
                            utf8_have = '0;
                            utf8_goal = '0;
                            if (total >= 2 && utf8_good(bs, total, cp)) begin
                                enc = '0;
                                for (int i = 0; i < total; i++) enc[8*i +: 8] = bs[i];
                                add_event(make_event(KIND_CHAR, cp, enc, 3'(total)));
                            end
                            else
                            begin
                                add_event(make_event(KIND_CHAR, REPL_CP, REPL_BYTES, REPL_LEN));
                                for (int i = total - 1; i >= 1; i--)
                                    if (replay.size() < 8) replay.push_back(bs[i]);
                            end
                        end
                    default:
                    begin
                        mode = ST_GROUND;
                        if (b == BYTE_ESC) mode = ST_ESC;
                        else if (b == BYTE_CR || b == BYTE_LF)
                            add_event(make_event(KIND_ENTER, '0, '0, '0));
                        else if (b == BYTE_TAB)
                            add_event(make_event(KIND_TAB, '0, '0, '0));
                        else if (b == BYTE_DEL || b == BYTE_BS)
                            add_event(make_event(KIND_BACKSPACE, '0, '0, '0));
                        else if (b < BYTE_SPACE)
                            add_event(make_event(KIND_CTRL, 21'(b + CTRL_OFFSET), '0, '0));
                        else if (b < 8'h80)
                            add_event(make_event(KIND_CHAR, 21'(b), 32'(b), 3'd1));
                        else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110)
                        begin
                            held_utf8 = {16'b0, b};
                            utf8_have = 3'd1;
                            utf8_goal = (b[7:5] == 3'b110) ? 3'd2 :
                                        (b[7:4] == 4'b1110) ? 3'd3 : 3'd4;
                            mode = ST_UTF8;
                        end
                        else
                            add_event(make_event(KIND_CHAR, REPL_CP, REPL_BYTES, REPL_LEN));
                    end
                endcase
            end
        end
        if (step_events.size() > 0) step_events[$].last_of_run = 1'b1;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("[%0d] %s: got %0h, expected %0h", cycle_count, field, got, want);
        fail_count++;
    endtask

    task automatic check_event(key_event_t got);
        key_event_t want;
        if (awaited_events.size() == 0) begin
            report("unexpected event, kind", got.key_kind, 0);
            return;
        end
        want = awaited_events.pop_front();
        if (got.key_kind != want.key_kind) report("key_kind", got.key_kind, want.key_kind);
        if (got.code_point != want.code_point)
            report("code_point", got.code_point, want.code_point);
        if (got.utf8_bytes != want.utf8_bytes)
            report("utf8_bytes", got.utf8_bytes, want.utf8_bytes);
        if (got.utf8_length != want.utf8_length)
            report("utf8_length", got.utf8_length, want.utf8_length);
        if (got.mod_shift != want.mod_shift) report("mod_shift", got.mod_shift, want.mod_shift);
        if (got.mod_alt != want.mod_alt) report("mod_alt", got.mod_alt, want.mod_alt);
        if (got.mod_ctrl != want.mod_ctrl) report("mod_ctrl", got.mod_ctrl, want.mod_ctrl);
        if (got.mouse_button != want.mouse_button)
            report("mouse_button", got.mouse_button, want.mouse_button);
        if (got.mouse_action != want.mouse_action)
            report("mouse_action", got.mouse_action, want.mouse_action);
        if (got.mouse_column != want.mouse_column)
            report("mouse_column", got.mouse_column, want.mouse_column);
        if (got.mouse_row != want.mouse_row) report("mouse_row", got.mouse_row, want.mouse_row);
        if (got.last_of_run != want.last_of_run)
            report("last_of_run", got.last_of_run, want.last_of_run);
    endtask

    // mostly back to back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void plan_byte(logic act, logic [7:0] b);
        plan_entry_t e;
        e.item.action = act;
        e.item.data_byte = b;
        e.gap = pick_gap();
        e.drain = 1'b0;
        e.hold = 1'b0;
        e.fixed = 1'b0;
        e.fixed_event = '0;
        byte_plan.push_back(e);
    endfunction

    function automatic void plan_text(string s);
        for (int i = 0; i < s.len(); i++) plan_byte(ACT_DATA, s[i]);
    endfunction

    // a decimal field: usually small, sometimes long enough to saturate
    function automatic void plan_number();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return;
        if (r == 1) begin
            for (int i = $urandom_range(5, 7); i > 0; i--)
                plan_byte(ACT_DATA, 8'(BYTE_ZERO + $urandom_range(0, 9)));
        end
        else
            plan_text($sformatf("%0d", $urandom_range(0, 300)));
    endfunction

    function automatic void plan_valid_utf8();
        int unsigned cp;
        case ($urandom_range(2, 4))
            2:
            begin
                cp = $urandom_range(8'h80, 11'h7FF);
                plan_byte(ACT_DATA, 8'(8'hC0 | (cp >> 6)));
            end
            3:
            begin
                do cp = $urandom_range(12'h800, 16'hFFFF);
                while (cp >= 16'hD800 && cp <= 16'hDFFF);
                plan_byte(ACT_DATA, 8'(8'hE0 | (cp >> 12)));
                plan_byte(ACT_DATA, 8'(8'h80 | ((cp >> 6) & 6'h3F)));
            end
            default:
            begin
                cp = $urandom_range(17'h10000, 21'h10FFFF);
                plan_byte(ACT_DATA, 8'(8'hF0 | (cp >> 18)));
                plan_byte(ACT_DATA, 8'(8'h80 | ((cp >> 12) & 6'h3F)));
                plan_byte(ACT_DATA, 8'(8'h80 | ((cp >> 6) & 6'h3F)));
            end
        endcase
        plan_byte(ACT_DATA, 8'(8'h80 | (cp & 6'h3F)));
    endfunction

    function automatic void plan_random_sequence();
        logic [7:0] finals [9];
        finals = '{BYTE_KEY_A, BYTE_KEY_B, BYTE_KEY_C, BYTE_KEY_D, BYTE_KEY_H,
                   BYTE_KEY_F, BYTE_KEY_Z, BYTE_TILDE, BYTE_TILDE};
        case ($urandom_range(0, 15))
            0, 1: plan_byte(ACT_DATA, 8'($urandom_range(8'h20, 8'h7E)));
            2: plan_byte(ACT_DATA, 8'($urandom_range(8'h00, 8'h1F)));
            3: plan_byte(ACT_DATA, $urandom_range(0, 1) ? BYTE_DEL : BYTE_BS);
            4, 5: plan_valid_utf8();
            6:
            begin
                plan_byte(ACT_DATA, 8'($urandom_range(8'hC0, 8'hFF)));
                for (int i = $urandom_range(0, 3); i > 0; i--)
                    plan_byte(ACT_DATA, 8'($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hBF)
                                                                : $urandom_range(0, 255)));
            end
            7, 8, 9:
            begin
                plan_byte(ACT_DATA, BYTE_ESC);
                plan_byte(ACT_DATA, $urandom_range(0, 3) ? BYTE_LBRACKET : BYTE_SS3);
                plan_number();
                if ($urandom_range(0, 1)) begin
                    plan_byte(ACT_DATA, BYTE_SEMI);
                    if ($urandom_range(0, 3) == 0) plan_byte(ACT_DATA, BYTE_SEMI);
                    if ($urandom_range(0, 1)) plan_text($sformatf("%0d", $urandom_range(1, 9)));
                    else plan_number();
                end
                if ($urandom_range(0, 7) == 0)
                    plan_byte(ACT_DATA, 8'($urandom_range(8'h20, 8'h2F)));
                if ($urandom_range(0, 7) == 0) plan_byte(ACT_FLUSH, 8'($urandom_range(0, 255)));
                plan_byte(ACT_DATA, 8'($urandom_range(0, 4) ? finals[$urandom_range(0, 8)]
                                                            : $urandom_range(8'h40, 8'h7E)));
            end
            10, 11:
            begin
                plan_byte(ACT_DATA, BYTE_ESC);
                plan_byte(ACT_DATA, BYTE_LBRACKET);
                plan_byte(ACT_DATA, BYTE_LESS);
                plan_text($sformatf("%0d", $urandom_range(0, 127)));
                plan_byte(ACT_DATA, BYTE_SEMI);
                plan_number();
                plan_byte(ACT_DATA, BYTE_SEMI);
                plan_number();
                if ($urandom_range(0, 7) == 0) begin
                    plan_byte(ACT_DATA, BYTE_SEMI);
                    plan_number();
                end
                if ($urandom_range(0, 7) == 0) plan_byte(ACT_DATA, 8'($urandom_range(0, 255)));
                plan_byte(ACT_DATA, $urandom_range(0, 1) ? BYTE_MOUSE_DN : BYTE_MOUSE_UP);
            end
            12: plan_byte(ACT_FLUSH, 8'($urandom_range(0, 255)));
            13:
            begin
                plan_byte(ACT_DATA, BYTE_ESC);
                if ($urandom_range(0, 1)) plan_byte(ACT_FLUSH, 8'($urandom_range(0, 255)));
                else plan_byte(ACT_DATA, 8'($urandom_range(0, 255)));
            end
            default: plan_byte(ACT_DATA, 8'($urandom_range(0, 255)));
        endcase
    endfunction

    // long receiver hold-off, counted here
    always @(posedge clk) begin
        if (hold_start) begin
            hold_on <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 1)
            hold_left <= hold_left - 1;
        else
            hold_on <= 1'b0;
    end

    // both sides of the handshake, sampled and driven at the rising edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            byte_valid <= 1'b0;
            byte_item <= '0;
            event_stall <= 1'b0;
            hold_start <= 1'b0;
        end
        else
        begin : edge_work
            logic      next_valid;
            key_byte_t next_item;
            logic      next_hold;
            next_valid = byte_valid;
            next_item = byte_item;
            next_hold = 1'b0;
            // result side
            if (event_valid && !event_stall) check_event(event_item);
            // input transfer taken: predict its events
            if (byte_valid && !byte_stall) begin
                decode_transfer(byte_item);
                if (offered.fixed) awaited_events.push_back(offered.fixed_event);
                else foreach (step_events[i]) awaited_events.push_back(step_events[i]);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0)
                    send_gap--;
                else if (byte_plan.size() > 0 &&
                         !(byte_plan[0].drain && awaited_events.size() != 0)) begin
                    offered = byte_plan.pop_front();
                    next_valid = 1'b1;
                    next_item = offered.item;
                    next_hold = offered.hold;
                    send_gap = offered.gap;
                end
            end
            byte_valid <= next_valid;
            byte_item <= next_item;
            hold_start <= next_hold;
            // receiver stalls
            if (hold_on)
                event_stall <= 1'b1;
            else if (rx_gap > 0) begin
                rx_gap--;
                event_stall <= 1'b1;
            end
            else
            begin
                rx_gap = pick_gap();
                event_stall <= (rx_gap > 0);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("terminal_key_sequence_decoder_core: mismatch");
            $finish;
        end
    end

    // directed bytes: action in the top bit
    logic [8:0] directed_bytes [N_DIRECTED] = '{
        9'h061, 9'h00D, 9'h001, 9'h0FF, 9'h000,          // plain, enter, ctrl, stray
        9'h01B, 9'h1A5,                                  // lone escape then flush
        9'h01B, 9'h05B, 9'h031, 9'h03B, 9'h035, 9'h041,  // up with ctrl modifier
        9'h01B, 9'h05B, 9'h033, 9'h07E,                  // delete
        9'h01B, 9'h078,                                  // escape then plain byte
        9'h0E0, 9'h080,                                  // overlong three-byte lead
        9'h0F0, 9'h09F, 9'h098, 9'h080                   // four-byte character
    };

    initial begin
        key_event_t fixed_events [N_DIRECTED];
        int         n_random;
        fixed_events = '{default: '0};
        fixed_events[0] = make_event(KIND_CHAR, 21'h61, 32'h61, 3'd1);
        fixed_events[1] = make_event(KIND_ENTER, '0, '0, '0);
        fixed_events[2] = make_event(KIND_CTRL, 21'h61, '0, '0);
        fixed_events[3] = make_event(KIND_CHAR, REPL_CP, REPL_BYTES, REPL_LEN);
        for (int i = 0; i < 4; i++) fixed_events[i].last_of_run = 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            plan_byte(directed_bytes[i][8], directed_bytes[i][7:0]);
            byte_plan[$].fixed = (i < 4);
            byte_plan[$].fixed_event = fixed_events[i];
        end
        n_random = 0;
        while (byte_plan.size() < N_DIRECTED + N_RANDOM) begin
            plan_random_sequence();
            n_random++;
            if (n_random == 60) byte_plan[$].hold = 1'b1;
            if (n_random == 150) byte_plan[$].drain = 1'b1;
        end

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        while (byte_plan.size() > 0 || byte_valid || awaited_events.size() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && awaited_events.size() == 0)
            $display("terminal_key_sequence_decoder_core: match");
        else
            $display("terminal_key_sequence_decoder_core: mismatch");
        $finish;
    end

endmodule
